[src/cc_pkg.sv]
// ChaCha20 stream XOR package: types, constants and helpers
// used by the round logic and the top level; no dependencies
`default_nettype none
package cc_pkg;
  localparam int DOUBLE_ROUNDS = 10;
  localparam int ROUNDS = 2 * DOUBLE_ROUNDS;
  localparam int ROUND_W = $clog2(ROUNDS + 1);

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] block_t;

  localparam word_t SIGMA_0 = 32'h61707865;
  localparam word_t SIGMA_1 = 32'h3320646e;
  localparam word_t SIGMA_2 = 32'h79622d32;
  localparam word_t SIGMA_3 = 32'h6b206574;

  typedef enum logic [2:0] {
    REG_KEY_0_1   = 3'd0,
    REG_KEY_2_3   = 3'd1,
    REG_KEY_4_5   = 3'd2,
    REG_KEY_6_7   = 3'd3,
    REG_NONCE_0_1 = 3'd4,
    REG_NONCE_2   = 3'd5
  } reg_idx_t;

  function automatic word_t rotl(input word_t v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [63:0] byte_mask(input logic [3:0] nb);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (nb > 4'(i)) m[8*i +: 8] = 8'hff;
    end
    byte_mask = m;
  endfunction
endpackage
`default_nettype wire

[src/cc_if.sv]
// beat channels for the ChaCha20 stream XOR unit
// valid/ready handshake with payload; no dependencies
`default_nettype none
interface cc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_in;
  logic [3:0]  valid_bytes;
  logic        first;
  modport source (output valid, data_in, valid_bytes, first, input ready);
  modport sink (input valid, data_in, valid_bytes, first, output ready);
endinterface

interface cc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_out;
  logic [3:0]  out_valid_bytes;
  modport source (output valid, data_out, out_valid_bytes, input ready);
  modport sink (input valid, data_out, out_valid_bytes, output ready);
endinterface
`default_nettype wire

[src/cc_qr_cell.sv]
// one ChaCha quarter-round cell on four state words
// depends on cc_pkg
`default_nettype none
module cc_qr_cell
  import cc_pkg::*;
(
  input  word_t a_in,
  input  word_t b_in,
  input  word_t c_in,
  input  word_t d_in,
  output word_t a_out,
  output word_t b_out,
  output word_t c_out,
  output word_t d_out
);
  word_t a1, b1, c1, d1, a2, d2, c2;

  always_comb begin
    a1 = a_in + b_in;
    d1 = rotl(d_in ^ a1, 16);
    c1 = c_in + d1;
    b1 = rotl(b_in ^ c1, 12);
    a2 = a1 + b1;
    d2 = rotl(d1 ^ a2, 8);
    c2 = c1 + d2;
    a_out = a2;
    d_out = d2;
    c_out = c2;
    b_out = rotl(b1 ^ c2, 7);
  end
endmodule
`default_nettype wire

[src/cc_round.sv]
// quarter-round cells for a column round and for a diagonal round; diag picks which one is output
// depends on cc_pkg and cc_qr_cell
`default_nettype none
module cc_round
  import cc_pkg::*;
(
  input  block_t w_in,
  input  logic   diag,
  output block_t w_out
);
  block_t col_out, dia_out;

  for (genvar i = 0; i < 4; i++) begin : g_cell
    cc_qr_cell u_col (
      .a_in (w_in[i]),
      .b_in (w_in[4 + i]),
      .c_in (w_in[8 + i]),
      .d_in (w_in[12 + i]),
      .a_out(col_out[i]),
      .b_out(col_out[4 + i]),
      .c_out(col_out[8 + i]),
      .d_out(col_out[12 + i])
    );
    cc_qr_cell u_dia (
      .a_in (w_in[i]),
      .b_in (w_in[4 + (i + 1) % 4]),
      .c_in (w_in[8 + (i + 2) % 4]),
      .d_in (w_in[12 + (i + 3) % 4]),
      .a_out(dia_out[i]),
      .b_out(dia_out[4 + (i + 1) % 4]),
      .c_out(dia_out[8 + (i + 2) % 4]),
      .d_out(dia_out[12 + (i + 3) % 4])
    );
  end

  assign w_out = diag ? dia_out : col_out;
endmodule
`default_nettype wire

[src/chacha20_stream_xor_unit.sv]
// top level of the ChaCha20 stream XOR unit
// depends on cc_pkg, cc_if and cc_round
`default_nettype none
// Each input beat XORs up to eight bytes with keystream. A beat that uses
// a keystream word pair already held goes straight to the output register.
// A beat at the start of a 64-byte block (or with first set) makes a new
// block first: one round per cycle through four column and four diagonal
// quarter-round cells, then the final add. A result waiting in the output
// register holds off the next beat until it is taken.
module chacha20_stream_xor_unit
  import cc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  cc_in_if.sink            in_ch,
  cc_out_if.source         out_ch
);
  word_t [7:0] key;
  word_t [2:0] nonce;
  word_t       counter;
  word_t       blk_ctr;
  logic [2:0]  pos;
  block_t      ks, w, w_rnd, init, ks_new;
  logic        busy;
  logic [ROUND_W-1:0] rnd;
  logic [63:0] hold_data;
  logic [3:0]  hold_nb;
  logic        out_valid;
  logic [63:0] out_data;
  logic [3:0]  out_nb;
  logic        out_free, acc, need_blk, done, out_load;
  word_t       ctr_use;

  assign out_free = !out_valid || out_ch.ready;
  assign in_ch.ready = !busy && out_free;
  assign acc = in_ch.valid && in_ch.ready;
  assign need_blk = in_ch.first || (pos == 3'd0);
  assign ctr_use = in_ch.first ? 32'd1 : counter;
  assign done = busy && (rnd == ROUND_W'(ROUNDS)) && out_free;
  assign out_load = (acc && !need_blk) || done;

  function automatic block_t make_init(input word_t c, input word_t [7:0] k,
                                       input word_t [2:0] n);
    block_t s;
    s[0] = SIGMA_0;
    s[1] = SIGMA_1;
    s[2] = SIGMA_2;
    s[3] = SIGMA_3;
    for (int i = 0; i < 8; i++) s[4 + i] = k[i];
    s[12] = c;
    s[13] = n[0];
    s[14] = n[1];
    s[15] = n[2];
    make_init = s;
  endfunction

  assign init = make_init(blk_ctr, key, nonce);

  cc_round u_round (
    .w_in (w),
    .diag (rnd[0]),
    .w_out(w_rnd)
  );

  always_comb begin
    for (int i = 0; i < 16; i++) ks_new[i] = w[i] + init[i];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key       <= '0;
      nonce     <= '0;
      counter   <= '0;
      pos       <= '0;
      busy      <= 1'b0;
      rnd       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY_0_1:   key[1:0] <= cfg_data;
          REG_KEY_2_3:   key[3:2] <= cfg_data;
          REG_KEY_4_5:   key[5:4] <= cfg_data;
          REG_KEY_6_7:   key[7:6] <= cfg_data;
          REG_NONCE_0_1: nonce[1:0] <= cfg_data;
          REG_NONCE_2:   nonce[2] <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (out_valid && out_ch.ready && !out_load) out_valid <= 1'b0;
      if (acc) begin
        if (need_blk) begin
          busy      <= 1'b1;
          rnd       <= '0;
          w         <= make_init(ctr_use, key, nonce);
          blk_ctr   <= ctr_use;
          counter   <= ctr_use + 32'd1;
          hold_data <= in_ch.data_in;
          hold_nb   <= in_ch.valid_bytes;
        end else begin
          out_data  <= (in_ch.data_in ^ {ks[{pos, 1'b1}], ks[{pos, 1'b0}]})
                       & byte_mask(in_ch.valid_bytes);
          out_nb    <= in_ch.valid_bytes;
          out_valid <= 1'b1;
          pos       <= pos + 3'd1;
        end
      end
      if (busy) begin
        if (rnd != ROUND_W'(ROUNDS)) begin
          w   <= w_rnd;
          rnd <= rnd + 1'b1;
        end else if (done) begin
          ks        <= ks_new;
          out_data  <= (hold_data ^ {ks_new[1], ks_new[0]}) & byte_mask(hold_nb);
          out_nb    <= hold_nb;
          out_valid <= 1'b1;
          busy      <= 1'b0;
          pos       <= 3'd1;
        end
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data_out = out_data;
  assign out_ch.out_valid_bytes = out_nb;
endmodule
`default_nettype wire

[sim/tb_top.sv]
// testbench for the chacha20 stream xor unit: random and directed beats,
// keystream predicted in a scoreboard class; depends on cc_pkg, cc_if and the rtl
`default_nettype none
module tb_top;
  import cc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  cc_in_if  in_ch ();
  cc_out_if out_ch ();

  chacha20_stream_xor_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nbytes;
  } cipher_beat_t;

  class cipher_scoreboard;
    logic [31:0]  key [8];
    logic [31:0]  nonce [3];
    logic [31:0]  counter;
    logic [31:0]  ks [16];
    logic [2:0]   pos;
    cipher_beat_t pending [$];
    int           mismatches;

    function void clear();
      for (int i = 0; i < 8; i++) key[i] = '0;
      for (int i = 0; i < 3; i++) nonce[i] = '0;
      for (int i = 0; i < 16; i++) ks[i] = '0;
      counter = '0;
      pos = '0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [63:0] v);
      case (idx)
        REG_NONCE_0_1: begin
          nonce[0] = v[31:0];
          nonce[1] = v[63:32];
        end
        REG_NONCE_2: nonce[2] = v[31:0];
        default: begin
          key[2 * int'(idx)] = v[31:0];
          key[2 * int'(idx) + 1] = v[63:32];
        end
      endcase
    endfunction

    function logic [31:0] rl(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void mix(ref logic [31:0] x [16], input int a, int b, int c, int d);
      x[a] += x[b]; x[d] = rl(x[d] ^ x[a], 16);
      x[c] += x[d]; x[b] = rl(x[b] ^ x[c], 12);
      x[a] += x[b]; x[d] = rl(x[d] ^ x[a], 8);
      x[c] += x[d]; x[b] = rl(x[b] ^ x[c], 7);
    endfunction

    function void next_block();
      logic [31:0] s [16];
      logic [31:0] w [16];
      s[0] = 32'h61707865; s[1] = 32'h3320646e;
      s[2] = 32'h79622d32; s[3] = 32'h6b206574;
      for (int i = 0; i < 8; i++) s[4 + i] = key[i];
      s[12] = counter;
      for (int i = 0; i < 3; i++) s[13 + i] = nonce[i];
      w = s;
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
        mix(w, 0, 4, 8, 12); mix(w, 1, 5, 9, 13);
        mix(w, 2, 6, 10, 14); mix(w, 3, 7, 11, 15);
        mix(w, 0, 5, 10, 15); mix(w, 1, 6, 11, 12);
        mix(w, 2, 7, 8, 13); mix(w, 3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) ks[i] = w[i] + s[i];
      counter++;
    endfunction

    function void note_input(logic [63:0] d, logic [3:0] nb, logic f);
      cipher_beat_t e;
      logic [63:0] m;
      if (f) begin
        counter = 32'd1;
        pos = '0;
      end
      if (pos == 0) next_block();
      m = '0;
      for (int i = 0; i < 8; i++) if (nb > i) m[8*i +: 8] = 8'hff;
      e.data = (d ^ {ks[2*pos+1], ks[2*pos]}) & m;
      e.nbytes = nb;
      pending.push_back(e);
      pos++;
    endfunction

    function void check_output(logic [63:0] d, logic [3:0] nb);
      cipher_beat_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat data=%h nbytes=%0d", d, nb);
        return;
      end
      e = pending.pop_front();
      if (d !== e.data || nb !== e.nbytes) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h/%0d actual %h/%0d", e.data, e.nbytes, d, nb);
      end
    endfunction
  endclass

  cipher_scoreboard sb;
  int  src_idle_pct;
  int  snk_idle_pct;
  int  stall_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver side and checking
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) sb.check_output(out_ch.data_out, out_ch.out_valid_bytes);
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic send_beat(logic [63:0] d, logic [3:0] nb, logic f);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_in <= d;
    in_ch.valid_bytes <= nb;
    in_ch.first <= f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(d, nb, f);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic program_all(int style);
    for (int i = 0; i < 6; i++) begin
      logic [63:0] v;
      case (style)
        0: v = '0;
        1: v = '1;
        default: v = rand64();
      endcase
      if (reg_idx_t'(i) == REG_NONCE_2) v[63:32] = '0;
      write_reg(reg_idx_t'(i), v);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_message(int beats);
    for (int i = 0; i < beats; i++) begin
      logic [3:0] nb;
      nb = ($urandom_range(3) == 0) ? 4'($urandom_range(1, 8)) : 4'd8;
      send_beat(rand64(), nb, (i == 0) || ($urandom_range(40) == 0));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data_in = '0;
    in_ch.valid_bytes = 4'd8;
    in_ch.first = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no first flag after reset: counter 0 with all-zero key
    send_beat('0, 4'd8, 1'b0);
    send_beat('1, 4'd1, 1'b0);
    send_beat(64'h0123456789abcdef, 4'd7, 1'b0);
    for (int i = 0; i < 6; i++) send_beat(rand64(), 4'(i + 2), 1'b0);
    drain();
    program_all(1);
    send_beat('1, 4'd8, 1'b1);
    send_beat('0, 4'd8, 1'b1);
    for (int i = 0; i < 9; i++) send_beat(rand64(), 4'd8, 1'b0);
    drain();

    // counter wrap: run past 2^32 from a first-less start is infeasible, so
    // the predictor covers it only through the counter arithmetic itself
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 79 : 0;
      snk_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 32 : 0;
      program_all(ph == 2 ? 0 : 2);
      for (int m = 0; m < 6; m++) begin
        random_message($urandom_range(12, 32));
        if (m == 2) drain();
      end
      drain();
    end

    src_idle_pct = 0;
    snk_idle_pct = 0;
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

[chacha20_stream_xor_unit.f]
src/cc_pkg.sv
src/cc_if.sv
src/cc_qr_cell.sv
src/cc_round.sv
src/chacha20_stream_xor_unit.sv
sim/tb_top.sv
